@@ rtl/gww_pkg.sv @@
// Shared constants, types and helpers for the greedy word wrap unit.
package gww_pkg;

  // Longest word held back before it is released unbroken
  localparam int WORD_MAX = 32;
  localparam int WL_W     = $clog2(WORD_MAX + 1);
  localparam int ADDR_W   = $clog2(WORD_MAX);

  localparam logic [7:0]  NL_CODE = 8'd10;
  localparam logic [7:0]  SP_CODE = 8'd32;
  localparam logic [15:0] WMAX16  = 16'hFFFF;

  // Word store access, one write and one read port
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

  // Load request into the output register
  typedef struct packed {
    logic       load;
    logic [7:0] char_code;
    logic       last;
    logic       ovf;
  } out_load_t;

  // Controller status seen by the top level
  typedef struct packed {
    logic            busy;
    logic [WL_W-1:0] word_length;
  } ctrl_status_t;

  // Clamp a 17-bit sum to 16 bits
  function automatic logic [15:0] sat16(input logic [16:0] v);
    sat16 = v[16] ? WMAX16 : v[15:0];
  endfunction

endpackage

@@ rtl/gww_ram.sv @@
// Generic single-clock RAM with one write port and a registered read port.
module gww_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/gww_ctrl.sv @@
// Wrap decision, line and word state, and the release sequencer over the word store.
module gww_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic [15:0]         line_max_width,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          char_code,
  input  logic [7:0]          char_width,
  input  logic                has_glyph,
  input  logic                end_of_text,
  input  logic                out_free,
  input  logic [7:0]          ram_rdata,
  output gww_pkg::ram_req_t   ram_req,
  output gww_pkg::out_load_t  ld,
  output gww_pkg::ctrl_status_t status
);
  import gww_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EMIT = 2'd1;
  localparam logic [1:0] ST_RDW  = 2'd2;

  // Architectural state
  logic [15:0]     line_width, line_width_next;
  logic            space_seen, space_seen_next;
  logic [WL_W-1:0] word_length, word_length_next;
  logic [15:0]     word_width, word_width_next;

  // Sequencer state
  logic [1:0]        st, st_next;
  logic              pre_pend, pre_pend_next;
  logic              suf_pend, suf_pend_next;
  logic              wr_pend, wr_pend_next;
  logic [WL_W-1:0]   cnt_left, cnt_left_next;
  logic [ADDR_W-1:0] rd_idx, rd_idx_next;
  logic              ovf_flag;
  logic [7:0]        suf_char;
  logic [7:0]        wr_char;
  logic [ADDR_W-1:0] wr_addr;

  // Decision terms for the offered character
  logic            accept;
  logic            is_nl, is_sp, hold, brk, full, ovf_rel, restart, drain, keep;
  logic [7:0]      eff_w;
  logic [16:0]     lw_add_w, lw_add_eff, ww_add_w, ww_add_eff;
  logic [15:0]     ww_base;
  logic [ADDR_W-1:0] hold_addr;

  assign in_ready = (st == ST_IDLE);
  assign accept   = in_valid && in_ready;

  assign is_nl   = (char_code == NL_CODE);
  assign is_sp   = (char_code == SP_CODE);
  assign hold    = !is_nl && !is_sp;
  assign eff_w   = has_glyph ? char_width : 8'd0;

  assign lw_add_w   = {1'b0, line_width} + {9'd0, char_width};
  assign lw_add_eff = {1'b0, line_width} + {9'd0, eff_w};
  assign ww_add_w   = {1'b0, word_width} + {9'd0, char_width};

  // Break only after a space has been seen on this line
  assign brk     = hold && has_glyph && space_seen && (lw_add_w > {1'b0, line_max_width});
  assign full    = (word_length == WL_W'(WORD_MAX));
  assign ovf_rel = hold && !brk && full;
  assign restart = brk || ovf_rel;
  assign drain   = is_nl || is_sp || restart || (hold && end_of_text);
  assign keep    = hold && !end_of_text;

  assign ww_base    = restart ? 16'd0 : word_width;
  assign ww_add_eff = {1'b0, ww_base} + {9'd0, eff_w};
  assign hold_addr  = restart ? '0 : word_length[ADDR_W-1:0];

  // Line and word state update on acceptance
  always_comb begin
    line_width_next  = line_width;
    space_seen_next  = space_seen;
    word_length_next = word_length;
    word_width_next  = word_width;
    if (accept) begin
      if (is_nl) begin
        line_width_next  = '0;
        space_seen_next  = 1'b0;
        word_length_next = '0;
        word_width_next  = '0;
      end else if (is_sp) begin
        line_width_next  = sat16(lw_add_w);
        space_seen_next  = 1'b1;
        word_length_next = '0;
        word_width_next  = '0;
      end else begin
        line_width_next  = brk ? sat16(ww_add_w) : sat16(lw_add_eff);
        space_seen_next  = brk ? 1'b0 : space_seen;
        word_length_next = (restart ? WL_W'(0) : word_length) + WL_W'(1);
        word_width_next  = sat16(ww_add_eff);
      end
      // End of text flushes everything
      if (end_of_text) begin
        line_width_next  = '0;
        space_seen_next  = 1'b0;
        word_length_next = '0;
        word_width_next  = '0;
      end
    end
  end

  // Release sequencer: leading newline, held bytes, trailing character
  always_comb begin
    st_next       = st;
    pre_pend_next = pre_pend;
    suf_pend_next = suf_pend;
    wr_pend_next  = wr_pend;
    cnt_left_next = cnt_left;
    rd_idx_next   = rd_idx;
    ram_req       = '0;
    ld            = '0;
    unique case (st)
      ST_IDLE: begin
        if (accept) begin
          pre_pend_next = brk;
          suf_pend_next = is_nl || is_sp || end_of_text;
          cnt_left_next = drain ? word_length : '0;
          rd_idx_next   = '0;
          wr_pend_next  = keep && drain;
          // A character that only joins the word is stored at once
          if (keep && !drain) begin
            ram_req.we    = 1'b1;
            ram_req.waddr = hold_addr;
            ram_req.wdata = char_code;
          end
          st_next = drain ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: begin
        priority if (pre_pend) begin
          if (out_free) begin
            ld.load       = 1'b1;
            ld.char_code  = NL_CODE;
            ld.last       = (cnt_left == '0) && !suf_pend;
            ld.ovf        = 1'b0;
            pre_pend_next = 1'b0;
          end
        end else if (cnt_left != '0) begin
          if (out_free) begin
            ram_req.re    = 1'b1;
            ram_req.raddr = rd_idx;
            st_next       = ST_RDW;
          end
        end else if (suf_pend) begin
          if (out_free) begin
            ld.load       = 1'b1;
            ld.char_code  = suf_char;
            ld.last       = 1'b1;
            ld.ovf        = 1'b0;
            suf_pend_next = 1'b0;
          end
        end else begin
          // Write back the new character once the old word is out
          ram_req.we    = wr_pend;
          ram_req.waddr = wr_addr;
          ram_req.wdata = wr_char;
          wr_pend_next  = 1'b0;
          st_next       = ST_IDLE;
        end
      end
      ST_RDW: begin
        ld.load       = 1'b1;
        ld.char_code  = ram_rdata;
        ld.last       = (cnt_left == WL_W'(1)) && !suf_pend;
        ld.ovf        = ovf_flag;
        cnt_left_next = cnt_left - WL_W'(1);
        rd_idx_next   = rd_idx + ADDR_W'(1);
        st_next       = ST_EMIT;
      end
      default: begin
        st_next = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      st          <= ST_IDLE;
      pre_pend    <= 1'b0;
      suf_pend    <= 1'b0;
      wr_pend     <= 1'b0;
      cnt_left    <= '0;
      rd_idx      <= '0;
      line_width  <= '0;
      space_seen  <= 1'b0;
      word_length <= '0;
      word_width  <= '0;
    end else begin
      st          <= st_next;
      pre_pend    <= pre_pend_next;
      suf_pend    <= suf_pend_next;
      wr_pend     <= wr_pend_next;
      cnt_left    <= cnt_left_next;
      rd_idx      <= rd_idx_next;
      line_width  <= line_width_next;
      space_seen  <= space_seen_next;
      word_length <= word_length_next;
      word_width  <= word_width_next;
    end
  end

  // Per-transaction payload
  always_ff @(posedge clk) begin
    if (accept) begin
      ovf_flag <= ovf_rel;
      suf_char <= char_code;
      wr_char  <= char_code;
      wr_addr  <= hold_addr;
    end
  end

  assign status.busy        = (st != ST_IDLE);
  assign status.word_length = word_length;

endmodule

@@ rtl/greedy_word_wrap_unit.sv @@
// Top level of the greedy word wrap unit: config register, word store, output register.
//
// Characters stream in one transaction at a time; each is either held in a
// 32-entry word store or causes a release of the held word with inserted or
// passed-through newlines and spaces. A character that only joins the held word
// is written into the store when it is accepted. A character that releases
// output is accepted, then the unit loads an inserted newline if there is one,
// reads each held byte (the word store has a single read port with a
// registered read) and loads it, loads a trailing character if there is one,
// and closes by writing the new character back into the store if it starts the
// next word; each load waits until the output register is free. Results leave
// through an output register, so the last result of one item can wait for
// out_ready while the next item is accepted. line_max_width is written over the
// cfg port and should only change while the unit is idle.
module greedy_word_wrap_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  char_code,
  input  logic [7:0]  char_width,
  input  logic        has_glyph,
  input  logic        end_of_text,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_char,
  output logic        last,
  output logic        word_overflow
);
  import gww_pkg::*;

  logic [15:0]  line_max_width;
  logic         out_free;
  logic [7:0]   ram_rdata;
  ram_req_t     ram_req;
  out_load_t    ld;
  ctrl_status_t status;

  // Configuration register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_max_width <= WMAX16;
    end else if (cfg_valid && cfg_ready) begin
      line_max_width <= cfg_data;
    end
  end

  // Word store
  gww_ram #(
    .WIDTH(8),
    .DEPTH(WORD_MAX)
  ) u_word_store (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

  // Decision and release sequencer
  gww_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .line_max_width (line_max_width),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .char_code      (char_code),
    .char_width     (char_width),
    .has_glyph      (has_glyph),
    .end_of_text    (end_of_text),
    .out_free       (out_free),
    .ram_rdata      (ram_rdata),
    .ram_req        (ram_req),
    .ld             (ld),
    .status         (status)
  );

  // Output register
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ld.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld.load) begin
      out_char      <= ld.char_code;
      last          <= ld.last;
      word_overflow <= ld.ovf;
    end
  end

  // Checks
  a_load_into_free: assert property (@(posedge clk) disable iff (rst)
    ld.load |-> out_free)
    else $error("output register overwritten while holding an untaken result");

  a_read_then_load: assert property (@(posedge clk) disable iff (rst)
    ram_req.re |=> ld.load)
    else $error("word store read not followed by an output load");

  a_word_len_bound: assert property (@(posedge clk) disable iff (rst)
    status.word_length <= WL_W'(WORD_MAX))
    else $error("held word length beyond the word store depth");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    status.busy |-> !in_ready && !ram_req.re || !ram_req.we)
    else $error("store read and write in the same cycle while releasing");

endmodule

@@ test/gww_checker.sv @@
// Checker for the greedy word wrap unit: predicts the output stream and compares each transaction.
module gww_checker
  import gww_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  char_code,
  input  logic [7:0]  char_width,
  input  logic        has_glyph,
  input  logic        end_of_text,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  out_char,
  input  logic        last,
  input  logic        word_overflow,
  output int          errors,
  output int          pending
);

  typedef struct packed {
    logic [7:0] code;
    logic       is_last;
    logic       ovf;
  } wrap_out_t;

  // Predicted state of the wrapper
  logic [15:0]     max_width_q;
  logic [15:0]     line_w;
  logic            space_on_line;
  logic [WL_W-1:0] held_len;
  logic [15:0]     held_w;
  logic [7:0]      held_chars [WORD_MAX];

  wrap_out_t expected_chars[$];
  int        emitted;   // results raised by the current transaction

  function automatic logic [15:0] add_clamped(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s > 17'h0FFFF) ? 16'hFFFF : s[15:0];
  endfunction

  task automatic emit(input logic [7:0] c, input logic ovf);
    wrap_out_t r;
    r.code    = c;
    r.is_last = 1'b0;
    r.ovf     = ovf;
    expected_chars = {expected_chars, r};
    emitted++;
  endtask

  task automatic flush_word(input logic ovf);
    for (int i = 0; i < held_len; i++) emit(held_chars[i], ovf);
    held_len = '0;
    held_w   = '0;
  endtask

  // Full store is released unbroken before the new byte goes in
  task automatic keep_char(input logic [7:0] c, input logic [7:0] w);
    if (held_len >= WORD_MAX) flush_word(1'b1);
    held_chars[held_len[ADDR_W-1:0]] = c;
    held_len++;
    held_w = add_clamped(held_w, {8'd0, w});
  endtask

  task automatic predict_wrap(input logic [7:0] c, input logic [7:0] w, input logic g,
                              input logic eot);
    logic [15:0] word_w_then;
    emitted = 0;
    if (c == NL_CODE) begin
      flush_word(1'b0);
      emit(NL_CODE, 1'b0);
      line_w        = '0;
      space_on_line = 1'b0;
    end else if (c == SP_CODE) begin
      // space width counts whether or not there is a glyph
      flush_word(1'b0);
      emit(SP_CODE, 1'b0);
      space_on_line = 1'b1;
      line_w        = add_clamped(line_w, {8'd0, w});
    end else if (g) begin
      if ((({9'd0, w} + {1'b0, line_w}) > {1'b0, max_width_q}) && space_on_line) begin
        // break: newline first, then the held word starts the new line
        word_w_then = held_w;
        emit(NL_CODE, 1'b0);
        flush_word(1'b0);
        space_on_line = 1'b0;
        line_w        = add_clamped(word_w_then, {8'd0, w});
      end else begin
        line_w = add_clamped(line_w, {8'd0, w});
      end
      keep_char(c, w);
    end else begin
      keep_char(c, 8'd0);
    end
    if (eot) begin
      flush_word(1'b0);
      line_w        = '0;
      space_on_line = 1'b0;
    end
    if (emitted > 0) expected_chars[expected_chars.size() - 1].is_last = 1'b1;
  endtask

  // Predict on accepted input, compare on accepted output
  always @(posedge clk) begin
    wrap_out_t want;
    if (rst) begin
      max_width_q   = WMAX16;
      line_w        = '0;
      space_on_line = 1'b0;
      held_len      = '0;
      held_w        = '0;
      errors        = 0;
      expected_chars.delete();
    end else begin
      if (cfg_valid && cfg_ready) max_width_q = cfg_data;
      if (in_valid && in_ready) predict_wrap(char_code, char_width, has_glyph, end_of_text);
      if (out_valid && out_ready) begin
        if (expected_chars.size() == 0) begin
          if (errors < 10)
            $display("%0t: result with nothing expected: char %02h last %0b ovf %0b",
                     $realtime, out_char, last, word_overflow);
          errors++;
        end else begin
          want = expected_chars.pop_front();
          if (out_char !== want.code || last !== want.is_last ||
              word_overflow !== want.ovf) begin
            if (errors < 10)
              $display("%0t: mismatch: expected char %02h last %0b ovf %0b, got char %02h last %0b ovf %0b",
                       $realtime, want.code, want.is_last, want.ovf,
                       out_char, last, word_overflow);
            errors++;
          end
        end
      end
    end
    pending <= expected_chars.size();
  end

endmodule

@@ test/tb.sv @@
// Testbench top for the greedy word wrap unit: clock, reset, stimulus and verdict.
module tb;
  import gww_pkg::*;

  localparam int SETTLE_CYCLES = 80;    // beyond the longest release of a full word
  localparam int HOLD_CYCLES   = 300;   // long output hold-off

  typedef enum int {SEP_SPACE, SEP_NEWLINE, SEP_EOT, SEP_NONE} sep_kind_t;

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  char_code;
  logic [7:0]  char_width;
  logic        has_glyph;
  logic        end_of_text;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_char;
  logic        last;
  logic        word_overflow;
  int          errors;
  int          pending;

  int hold_reqs  = 0;
  int burst_left = 0;
  int chars_sent = 0;

  greedy_word_wrap_unit u_dut (.*);

  gww_checker u_check (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10000000;
    $display("greedy_word_wrap_unit test failed");
    $finish;
  end

  // Output side: random ready patterns, plus a long hold-off on request
  initial begin : out_side
    int run_left;
    int mode;
    int holds_done;
    run_left   = 0;
    mode       = 0;
    holds_done = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_reqs != holds_done) begin
        holds_done++;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if (run_left == 0) begin
        mode     = $urandom_range(0, 3);
        run_left = $urandom_range(8, 120);
      end
      run_left--;
      case (mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 3) != 0);
        2: out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= run_left[2];
      endcase
    end
  end

  // One character transaction; bursts of random length separated by gaps
  task automatic offer_char(input logic [7:0] c, input logic [7:0] w, input logic g,
                            input logic eot);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 60);
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    burst_left--;
    in_valid    <= 1'b1;
    char_code   <= c;
    char_width  <= w;
    has_glyph   <= g;
    end_of_text <= eot;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    chars_sent++;
  endtask

  // Stop offering and wait until every expected result has come out
  task automatic drain_output();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_line_limit(input logic [15:0] v);
    drain_output();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // A word of random content followed by a space or newline, ended by end of text, or left open
  task automatic send_word(input int max_w);
    int        len;
    sep_kind_t sep;
    logic [7:0] c;
    if ($urandom_range(0, 9) == 0) len = $urandom_range(25, 40);
    else len = $urandom_range(1, 8);
    case ($urandom_range(0, 19))
      14, 15, 16: sep = SEP_NEWLINE;
      17, 18:     sep = SEP_EOT;
      19:         sep = SEP_NONE;
      default:    sep = SEP_SPACE;
    endcase
    for (int i = 0; i < len; i++) begin
      c = 8'($urandom_range(0, 255));
      if (c == NL_CODE || c == SP_CODE) c = 8'h5F;
      offer_char(c, 8'($urandom_range(0, max_w)), ($urandom_range(0, 7) != 0),
                 (sep == SEP_EOT) && (i == len - 1));
    end
    if (sep == SEP_SPACE)
      offer_char(SP_CODE, 8'($urandom_range(0, max_w)), 1'($urandom_range(0, 1)), 1'b0);
    else if (sep == SEP_NEWLINE)
      offer_char(NL_CODE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0);
  endtask

  // Unshaped bytes, separators and end-of-text marks included
  task automatic send_noise();
    logic [7:0] c;
    repeat ($urandom_range(1, 4)) begin
      case ($urandom_range(0, 7))
        0:       c = NL_CODE;
        1:       c = SP_CODE;
        default: c = 8'($urandom_range(0, 255));
      endcase
      offer_char(c, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                 ($urandom_range(0, 15) == 0));
    end
  endtask

  task automatic run_text(input int n_items, input int max_w);
    int stop_at;
    stop_at = chars_sent + n_items;
    while (chars_sent < stop_at) begin
      if ($urandom_range(0, 3) != 0) send_word(max_w);
      else send_noise();
    end
  endtask

  initial begin : stim
    rst         <= 1'b1;
    cfg_valid   <= 1'b0;
    cfg_data    <= '0;
    in_valid    <= 1'b0;
    char_code   <= '0;
    char_width  <= '0;
    has_glyph   <= 1'b0;
    end_of_text <= 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Limit at its reset value: separators, glyph-less bytes, end of text
    offer_char("H", 8'd255, 1'b1, 1'b0);
    offer_char("i", 8'd0, 1'b1, 1'b0);
    offer_char(SP_CODE, 8'd255, 1'b0, 1'b0);
    offer_char(8'hFF, 8'd255, 1'b0, 1'b0);
    offer_char(8'h00, 8'd1, 1'b1, 1'b0);
    offer_char(NL_CODE, 8'd255, 1'b1, 1'b0);
    offer_char("x", 8'd7, 1'b1, 1'b1);
    offer_char(SP_CODE, 8'd0, 1'b1, 1'b1);
    offer_char(NL_CODE, 8'd0, 1'b0, 1'b1);
    offer_char(8'h80, 8'd200, 1'b0, 1'b1);

    // Zero limit: every glyph after a space breaks, even at zero width
    set_line_limit(16'd0);
    offer_char("a", 8'd3, 1'b1, 1'b0);
    offer_char(SP_CODE, 8'd1, 1'b1, 1'b0);
    offer_char("b", 8'd1, 1'b1, 1'b0);
    offer_char("c", 8'd0, 1'b1, 1'b0);
    offer_char(SP_CODE, 8'd0, 1'b1, 1'b0);
    offer_char("d", 8'd0, 1'b1, 1'b0);
    offer_char("e", 8'd255, 1'b0, 1'b0);
    offer_char(NL_CODE, 8'd0, 1'b1, 1'b0);

    // Exact fit, then one unit over
    set_line_limit(16'd20);
    offer_char("a", 8'd10, 1'b1, 1'b0);
    offer_char("b", 8'd5, 1'b1, 1'b0);
    offer_char(SP_CODE, 8'd3, 1'b1, 1'b0);
    offer_char("c", 8'd2, 1'b1, 1'b0);
    offer_char("d", 8'd1, 1'b1, 1'b0);
    offer_char(NL_CODE, 8'd4, 1'b1, 1'b1);

    // Word longer than the store: released unbroken, then a fresh word
    repeat (34) offer_char("k", 8'd1, 1'b1, 1'b0);
    offer_char(SP_CODE, 8'd1, 1'b1, 1'b0);

    // Random text across a range of limits
    set_line_limit(16'd0);
    run_text(5, 255);
    set_line_limit(16'hFFFF);
    run_text(5, 255);
    set_line_limit(16'($urandom_range(16, 200)));
    hold_reqs <= hold_reqs + 1;   // output held off while input keeps coming
    run_text(5, 40);
    set_line_limit(16'($urandom_range(200, 2000)));
    run_text(5, 255);
    set_line_limit(16'($urandom_range(16, 200)));
    run_text(5, 40);
    set_line_limit(16'($urandom_range(0, 65535)));
    run_text(5, 255);

    // Line width saturation: spaces push the line past 16 bits, then a
    // one-unit glyph must still break
    set_line_limit(16'hFFFF);
    offer_char("w", 8'd255, 1'b1, 1'b0);
    repeat (262) offer_char(SP_CODE, 8'd255, 1'($urandom_range(0, 1)), 1'b0);
    offer_char("z", 8'd1, 1'b1, 1'b0);
    offer_char("q", 8'd255, 1'b1, 1'b0);
    offer_char(NL_CODE, 8'd0, 1'b1, 1'b1);

    drain_output();
    repeat (20) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("greedy_word_wrap_unit test passed");
    end else begin
      $display("greedy_word_wrap_unit test failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/gww_pkg.sv
rtl/gww_ram.sv
rtl/gww_ctrl.sv
rtl/greedy_word_wrap_unit.sv
test/gww_checker.sv
test/tb.sv
